@@ hdl/bre_pkg.sv @@
// Shared types, codes and helpers for the budgeted residency evictor.
package bre_pkg;

  localparam int SLOTS_DEF = 32;

  localparam logic [2:0] CMD_REGISTER = 3'd0;
  localparam logic [2:0] CMD_RESERVE  = 3'd1;
  localparam logic [2:0] CMD_PIN      = 3'd2;
  localparam logic [2:0] CMD_UNPIN    = 3'd3;
  localparam logic [2:0] CMD_ACQUIRE  = 3'd4;
  localparam logic [2:0] CMD_RELEASE  = 3'd5;
  localparam logic [2:0] CMD_TOUCH    = 3'd6;
  localparam logic [2:0] CMD_QUERY    = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUDGET  = 2'd1;
  localparam logic [1:0] ST_NO_VICT = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [1:0] RES_HOST = 2'd0;
  localparam logic [1:0] RES_DEV  = 2'd1;
  localparam logic [1:0] RES_BOTH = 2'd2;
  localparam logic [1:0] RES_BAD  = 2'd3;

  localparam logic [1:0] POL_LRU    = 2'd0;
  localparam logic [1:0] POL_LAYER  = 2'd1;
  localparam logic [1:0] POL_EXPERT = 2'd2;
  localparam logic [1:0] POL_OFF    = 2'd3;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_POLICY = 1'b1;

  typedef struct packed {
    logic [39:0]        size;
    logic signed [10:0] layer;
    logic               expert;
    logic               fixed;
    logic               pin;
    logic [15:0]        refs;
    logic [63:0]        last_use;
    logic [1:0]         where;
  } entry_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [39:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {9'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

endpackage

@@ hdl/bre_entry_ram.sv @@
// Slot table memory: one write port, one registered read port.
module bre_entry_ram #(
  parameter int SLOTS = bre_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  bre_pkg::entry_t          wdata,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output bre_pkg::entry_t          rdata
);
  import bre_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/bre_victim_sel.sv @@
// Victim selection: folds one scanned slot per cycle into the best candidate.
module bre_victim_sel #(
  parameter int SLOTS = bre_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     eval,
  input  logic                     slot_valid,
  input  logic [$clog2(SLOTS)-1:0] idx,
  input  bre_pkg::entry_t          rec,
  input  logic [1:0]               policy,
  input  logic signed [10:0]       cur_layer,
  output logic                     found,
  output logic [$clog2(SLOTS)-1:0] best_idx,
  output bre_pkg::entry_t          best_rec
);
  import bre_pkg::*;

  logic [10:0]        best_dist;
  logic               elig;
  logic               take;
  logic signed [11:0] diff;
  logic [10:0]        gap;

  always_comb begin
    elig = slot_valid && (rec.where != RES_HOST) && !rec.fixed && !rec.pin &&
           (rec.refs == 16'd0);
    diff = {rec.layer[10], rec.layer} - {cur_layer[10], cur_layer};
    if (!rec.layer[10] && !cur_layer[10]) begin
      gap = diff[11] ? 11'(-diff) : diff[10:0];
    end else begin
      gap = '0;
    end
    case (policy)
      POL_LRU:    take = !found || (rec.last_use < best_rec.last_use);
      POL_LAYER:  take = !found || (gap > best_dist);
      POL_EXPERT: take = !found || (rec.expert && (rec.last_use < best_rec.last_use));
      default:    take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (eval && elig && take) begin
      found <= 1'b1;
    end
    if (eval && elig && take) begin
      best_idx  <= idx;
      best_rec  <= rec;
      best_dist <= gap;
    end
  end

endmodule

@@ hdl/budgeted_residency_evictor_core.sv @@
// Top level: command sequencer, byte count and result register.
// Sequence: most commands pass S_RD and S_EMIT; a reserve that fits also passes S_CHECK;
// each victim of a reserve adds a scan of all SLOTS slots through the memory, then S_LASTEV and S_DECIDE.
// Throughput: one request at a time; the next is taken once the last result is queued.
// Reset: synchronous, clears valid marks, byte count, registers and handshakes.
module budgeted_residency_evictor_core #(
  parameter int SLOTS = bre_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic [4:0]         slot,
  input  logic [39:0]        obj_size,
  input  logic signed [10:0] layer,
  input  logic               is_expert,
  input  logic               is_fixed,
  input  logic [1:0]         residency,
  input  logic [63:0]        timestamp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [47:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_eviction,
  output logic [4:0]         evicted_slot,
  output logic               last,
  output logic [1:0]         status,
  output logic [47:0]        used_bytes,
  output logic [47:0]        free_bytes,
  output logic [1:0]         entry_residency,
  output logic               entry_pinned,
  output logic [15:0]        entry_refs
);
  import bre_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_LASTEV = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]         state;
  logic [SLOTS-1:0]   valid;
  logic [47:0]        bytes;
  logic [47:0]        budget;
  logic [1:0]         policy;

  logic [2:0]         cmd_r;
  logic [IW-1:0]      sidx;
  logic               in_range;
  logic [39:0]        size_r;
  logic signed [10:0] layer_r;
  logic               expert_r;
  logic               static_r;
  logic [1:0]         res_r;
  logic [63:0]        ts_r;
  logic               known;
  entry_t             cur;

  logic               p_ev;
  logic [4:0]         p_slot;
  logic               p_last;
  logic [1:0]         p_status;
  logic [1:0]         p_res;
  logic               p_pin;
  logic [15:0]        p_refs;

  logic [CW-1:0]      scan_cnt;
  logic               eval_v;
  logic [IW-1:0]      eval_idx;

  logic               we;
  logic [IW-1:0]      waddr;
  entry_t             wdata;
  logic [IW-1:0]      raddr;
  entry_t             rdata;

  logic               found;
  logic [IW-1:0]      best_idx;
  entry_t             best_rec;
  logic               clear_sel;
  logic               need_evict;
  logic               too_big;
  logic               load_out;
  logic               rd_known;

  bre_entry_ram #(.SLOTS(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  bre_victim_sel #(.SLOTS(SLOTS)) u_sel (
    .clk(clk), .rst(rst), .clear(clear_sel), .eval(eval_v), .slot_valid(valid[eval_idx]),
    .idx(eval_idx), .rec(rdata), .policy(policy), .cur_layer(layer_r), .found(found),
    .best_idx(best_idx), .best_rec(best_rec)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state == S_EMIT) && (!out_valid || out_ready);
  assign rd_known  = in_range && valid[sidx];
  assign clear_sel = (state == S_CHECK);
  assign too_big   = (budget != 48'd0) && ({8'd0, size_r} > budget);
  assign need_evict = (budget != 48'd0) &&
                      (({1'b0, bytes} + {9'b0, size_r}) > {1'b0, budget});

  always_comb begin
    raddr = (state == S_IDLE) ? IW'(slot) : IW'(scan_cnt);
    we    = 1'b0;
    waddr = sidx;
    wdata = rdata;
    case (state)
      S_RD: begin
        if (cmd_r == CMD_REGISTER) begin
          we             = in_range;
          wdata.size     = size_r;
          wdata.layer    = layer_r;
          wdata.expert   = expert_r;
          wdata.fixed    = static_r;
          wdata.pin      = 1'b0;
          wdata.refs     = 16'd0;
          wdata.last_use = 64'd0;
          wdata.where    = (res_r == RES_BAD) ? RES_HOST : res_r;
        end else if (cmd_r != CMD_RESERVE && cmd_r != CMD_QUERY) begin
          we = rd_known;
          case (cmd_r)
            CMD_PIN:     wdata.pin = 1'b1;
            CMD_UNPIN:   wdata.pin = 1'b0;
            CMD_ACQUIRE: if (rdata.refs != 16'hFFFF) wdata.refs = rdata.refs + 16'd1;
            CMD_RELEASE: if (rdata.refs != 16'd0) wdata.refs = rdata.refs - 16'd1;
            CMD_TOUCH:   wdata.last_use = ts_r;
            default:     ;
          endcase
        end
      end
      S_CHECK: begin
        we          = !need_evict && known;
        wdata       = cur;
        wdata.where = RES_BOTH;
      end
      S_DECIDE: begin
        we          = found;
        waddr       = best_idx;
        wdata       = best_rec;
        wdata.where = RES_HOST;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      bytes     <= '0;
      budget    <= '0;
      policy    <= POL_LRU;
      out_valid <= 1'b0;
      eval_v    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_BUDGET) budget <= cfg_data;
        else policy <= cfg_data[1:0];
      end
      eval_v <= (state == S_SCAN);
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: if (in_valid) state <= S_RD;
        S_RD: begin
          if (cmd_r == CMD_RESERVE && !too_big && !(rd_known && rdata.where != RES_HOST)) begin
            state <= S_CHECK;
          end else begin
            state <= S_EMIT;
          end
          if (cmd_r == CMD_REGISTER && in_range) begin
            valid[sidx] <= 1'b1;
            if (res_r != RES_HOST && res_r != RES_BAD) bytes <= sat_add48(bytes, size_r);
          end
        end
        S_CHECK: begin
          if (need_evict) begin
            state <= S_SCAN;
          end else begin
            bytes <= sat_add48(bytes, size_r);
            state <= S_EMIT;
          end
        end
        S_SCAN: if (scan_cnt == CW'(SLOTS - 1)) state <= S_LASTEV;
        S_LASTEV: state <= S_DECIDE;
        S_DECIDE: begin
          if (found) begin
            bytes <= (bytes >= {8'd0, best_rec.size}) ? bytes - {8'd0, best_rec.size} : '0;
          end
          state <= S_EMIT;
        end
        S_EMIT: if (load_out) state <= p_last ? S_IDLE : S_CHECK;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request capture, pending result and scan counter
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_r    <= command;
      sidx     <= IW'(slot);
      in_range <= {1'b0, slot} < 6'(SLOTS);
      size_r   <= obj_size;
      layer_r  <= layer;
      expert_r <= is_expert;
      static_r <= is_fixed;
      res_r    <= residency;
      ts_r     <= timestamp;
    end
    if (state == S_CHECK) scan_cnt <= '0;
    else if (state == S_SCAN) scan_cnt <= scan_cnt + CW'(1);
    eval_idx <= IW'(scan_cnt);
    case (state)
      S_RD: begin
        known  <= rd_known;
        cur    <= rdata;
        p_ev   <= 1'b0;
        p_slot <= 5'd0;
        p_last <= 1'b1;
        if (cmd_r == CMD_REGISTER) p_status <= in_range ? ST_OK : ST_UNKNOWN;
        else if (cmd_r == CMD_RESERVE) p_status <= too_big ? ST_BUDGET : ST_OK;
        else p_status <= rd_known ? ST_OK : ST_UNKNOWN;
        if (cmd_r == CMD_QUERY && rd_known) begin
          p_res  <= rdata.where;
          p_pin  <= rdata.pin;
          p_refs <= rdata.refs;
        end else begin
          p_res  <= RES_HOST;
          p_pin  <= 1'b0;
          p_refs <= 16'd0;
        end
      end
      S_CHECK: begin
        p_ev     <= 1'b0;
        p_slot   <= 5'd0;
        p_last   <= 1'b1;
        p_status <= ST_OK;
      end
      S_DECIDE: begin
        p_ev     <= found;
        p_slot   <= found ? 5'(best_idx) : 5'd0;
        p_last   <= !found;
        p_status <= found ? ST_OK : ST_NO_VICT;
      end
      default: ;
    endcase
    if (load_out) begin
      is_eviction     <= p_ev;
      evicted_slot    <= p_slot;
      last            <= p_last;
      status          <= p_status;
      used_bytes      <= bytes;
      free_bytes      <= (budget > bytes) ? budget - bytes : '0;
      entry_residency <= p_res;
      entry_pinned    <= p_pin;
      entry_refs      <= p_refs;
    end
  end

endmodule
